// File: src/piqt_pkg.sv
// piqt_pkg: shared constants and operand tables for the quadrilateral test pipeline.
// No dependencies; used by point_in_quadrilateral_test_top.
`timescale 1ns / 1ps
`default_nettype none

package piqt_pkg;

  // configuration register file
  localparam int CornerW    = 60;
  localparam int DataW      = 64;
  localparam int NumCorners = 4;
  localparam int AddrW      = $clog2(NumCorners) + 3;

  // register indexes, also the corner indexes
  localparam logic [1:0] CORNER_A = 2'd0;
  localparam logic [1:0] CORNER_B = 2'd1;
  localparam logic [1:0] CORNER_C = 2'd2;
  localparam logic [1:0] CORNER_D = 2'd3;

  // edge vectors relative to corner A
  localparam int NumEdges = 4;
  localparam logic [1:0] EDGE_B = 2'd0;  // B - A
  localparam logic [1:0] EDGE_C = 2'd1;  // C - A
  localparam logic [1:0] EDGE_D = 2'd2;  // D - A
  localparam logic [1:0] EDGE_P = 2'd3;  // P - A

  // dot products of both triangles; cc and pc are shared by the two
  localparam int NumDots = 8;
  localparam logic [2:0] DOT_BB = 3'd0;
  localparam logic [2:0] DOT_BC = 3'd1;
  localparam logic [2:0] DOT_CC = 3'd2;
  localparam logic [2:0] DOT_CD = 3'd3;
  localparam logic [2:0] DOT_DD = 3'd4;
  localparam logic [2:0] DOT_PB = 3'd5;
  localparam logic [2:0] DOT_PC = 3'd6;
  localparam logic [2:0] DOT_PD = 3'd7;

  localparam logic [1:0] DOT_A [NumDots] = '{
    EDGE_B, EDGE_B, EDGE_C, EDGE_C, EDGE_D, EDGE_P, EDGE_P, EDGE_P};
  localparam logic [1:0] DOT_B [NumDots] = '{
    EDGE_B, EDGE_C, EDGE_C, EDGE_D, EDGE_D, EDGE_B, EDGE_C, EDGE_D};

  // wide products, six per triangle: den, unum and vnum as plus/minus term pairs
  localparam int NumTris     = 2;
  localparam int TermsPerTri = 6;
  localparam int NumTerms    = NumTris * TermsPerTri;
  localparam int TERM_DEN_P  = 0;
  localparam int TERM_DEN_N  = 1;
  localparam int TERM_UN_P   = 2;
  localparam int TERM_UN_N   = 3;
  localparam int TERM_VN_P   = 4;
  localparam int TERM_VN_N   = 5;

  // triangle ABC: d00=bb d01=bc d11=cc d20=pb d21=pc
  // triangle ACD: d00=cc d01=cd d11=dd d20=pc d21=pd
  localparam logic [2:0] MUL_A [NumTerms] = '{
    DOT_BB, DOT_BC, DOT_CC, DOT_BC, DOT_BB, DOT_BC,
    DOT_CC, DOT_CD, DOT_DD, DOT_CD, DOT_CC, DOT_CD};
  localparam logic [2:0] MUL_B [NumTerms] = '{
    DOT_CC, DOT_BC, DOT_PB, DOT_PC, DOT_PC, DOT_PB,
    DOT_DD, DOT_CD, DOT_PC, DOT_PD, DOT_PD, DOT_PC};

  localparam int NumStages = 8;

endpackage

`default_nettype wire

// File: src/point_in_quadrilateral_test_top.sv
// Throughput one item per cycle while the output is not stalled by out_ready_i.
// The eight register stages advance together; they hold while a result waits at the output.
// Wide 44x44 products are split into 22-bit partial products over two stages.
// Reset clears all stage valid bits and the four corner registers to zero.
// Depends on piqt_pkg (constants and operand tables).
`timescale 1ns / 1ps
`default_nettype none

module point_in_quadrilateral_test_top #(
  parameter int MAX_CLIENTS = 16,
  parameter int COORD_BITS  = 20
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // apb configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [piqt_pkg::AddrW-1:0]            paddr,
  input  logic [piqt_pkg::DataW-1:0]            pwdata,
  output logic [piqt_pkg::DataW-1:0]            prdata,
  output logic                                  pready,
  // position reports
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [COORD_BITS-1:0]          pos_x_i,
  input  logic signed [COORD_BITS-1:0]          pos_y_i,
  input  logic signed [COORD_BITS-1:0]          pos_z_i,
  input  logic [((MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1)-1:0] client_port_i,
  // answers
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  in_danger_o,
  output logic [((MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1)-1:0] reply_port_o
);

  localparam int PortW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int CW    = COORD_BITS;
  localparam int XW    = (3 * CW > piqt_pkg::CornerW) ? 3 * CW : piqt_pkg::CornerW;
  localparam int EW    = CW + 1;        // edge component
  localparam int PW    = 2 * EW;        // component product
  localparam int DW    = PW + 2;        // dot product
  localparam int LW    = DW / 2;        // low split, unsigned
  localparam int HW    = DW - LW;       // high split, signed
  localparam int CrW   = HW + LW + 1;   // cross partial product
  localparam int SumW  = CrW + 1;
  localparam int FW    = 2 * DW;        // full product
  localparam int NW    = FW + 1;        // den, unum, vnum
  localparam int SW    = NW + 1;        // unum + vnum
  localparam int NS    = piqt_pkg::NumStages;

  // ---------------------------------------------------------------------------
  // configuration registers
  logic [piqt_pkg::CornerW-1:0] corner_q [piqt_pkg::NumCorners];
  logic [1:0]                   cfg_idx;
  logic                         cfg_wr;

  assign cfg_idx = paddr[piqt_pkg::AddrW-1:3];
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign pready  = 1'b1;
  assign prdata  = piqt_pkg::DataW'(corner_q[cfg_idx]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < piqt_pkg::NumCorners; k++) begin
        corner_q[k] <= '0;
      end
    end else if (cfg_wr) begin
      corner_q[cfg_idx] <= pwdata[piqt_pkg::CornerW-1:0];
    end
  end

  // unpack corners, bits above three coordinates are ignored
  logic signed [CW-1:0] crn [piqt_pkg::NumCorners][3];
  logic signed [CW-1:0] pos [3];

  always_comb begin
    logic [XW-1:0] cx;
    cx = '0;
    for (int k = 0; k < piqt_pkg::NumCorners; k++) begin
      cx = XW'(corner_q[k]);
      for (int ax = 0; ax < 3; ax++) begin
        crn[k][ax] = $signed(cx[ax*CW +: CW]);
      end
    end
  end

  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;

  // ---------------------------------------------------------------------------
  // pipeline control: all stages advance together
  logic          en;
  logic [NS-1:0] vld_q;
  logic [PortW-1:0] port_q [NS];

  assign en          = ~vld_q[NS-1] | out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      port_q[0] <= client_port_i;
      for (int k = 1; k < NS; k++) begin
        port_q[k] <= port_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: edge vectors
  logic signed [EW-1:0] e1_d [piqt_pkg::NumEdges][3];
  logic signed [EW-1:0] e1_q [piqt_pkg::NumEdges][3];

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      e1_d[piqt_pkg::EDGE_B][ax] = EW'(crn[piqt_pkg::CORNER_B][ax])
                                   - EW'(crn[piqt_pkg::CORNER_A][ax]);
      e1_d[piqt_pkg::EDGE_C][ax] = EW'(crn[piqt_pkg::CORNER_C][ax])
                                   - EW'(crn[piqt_pkg::CORNER_A][ax]);
      e1_d[piqt_pkg::EDGE_D][ax] = EW'(crn[piqt_pkg::CORNER_D][ax])
                                   - EW'(crn[piqt_pkg::CORNER_A][ax]);
      e1_d[piqt_pkg::EDGE_P][ax] = EW'(pos[ax]) - EW'(crn[piqt_pkg::CORNER_A][ax]);
    end
  end

  // stage 2: component products
  logic signed [PW-1:0] p2_d [piqt_pkg::NumDots][3];
  logic signed [PW-1:0] p2_q [piqt_pkg::NumDots][3];

  always_comb begin
    for (int i = 0; i < piqt_pkg::NumDots; i++) begin
      for (int ax = 0; ax < 3; ax++) begin
        p2_d[i][ax] = PW'(e1_q[piqt_pkg::DOT_A[i]][ax]) * PW'(e1_q[piqt_pkg::DOT_B[i]][ax]);
      end
    end
  end

  // stage 3: dot products
  logic signed [DW-1:0] d3_d [piqt_pkg::NumDots];
  logic signed [DW-1:0] d3_q [piqt_pkg::NumDots];

  always_comb begin
    for (int i = 0; i < piqt_pkg::NumDots; i++) begin
      d3_d[i] = DW'(p2_q[i][0]) + DW'(p2_q[i][1]) + DW'(p2_q[i][2]);
    end
  end

  // stage 4: partial products of the wide terms
  logic signed [2*HW-1:0] hh4_d [piqt_pkg::NumTerms];
  logic        [2*LW-1:0] ll4_d [piqt_pkg::NumTerms];
  logic signed [CrW-1:0]  xa4_d [piqt_pkg::NumTerms];
  logic signed [CrW-1:0]  xb4_d [piqt_pkg::NumTerms];
  logic signed [2*HW-1:0] hh4_q [piqt_pkg::NumTerms];
  logic        [2*LW-1:0] ll4_q [piqt_pkg::NumTerms];
  logic signed [CrW-1:0]  xa4_q [piqt_pkg::NumTerms];
  logic signed [CrW-1:0]  xb4_q [piqt_pkg::NumTerms];

  always_comb begin
    logic [DW-1:0] opa;
    logic [DW-1:0] opb;
    opa = '0;
    opb = '0;
    for (int j = 0; j < piqt_pkg::NumTerms; j++) begin
      opa = d3_q[piqt_pkg::MUL_A[j]];
      opb = d3_q[piqt_pkg::MUL_B[j]];
      hh4_d[j] = (2*HW)'($signed(opa[DW-1:LW])) * (2*HW)'($signed(opb[DW-1:LW]));
      ll4_d[j] = (2*LW)'(opa[LW-1:0]) * (2*LW)'(opb[LW-1:0]);
      xa4_d[j] = CrW'($signed(opa[DW-1:LW])) * $signed(CrW'(opb[LW-1:0]));
      xb4_d[j] = CrW'($signed(opb[DW-1:LW])) * $signed(CrW'(opa[LW-1:0]));
    end
  end

  // stage 5: recombine, high*high and low*low sit side by side
  logic signed [FW-1:0] f5_d [piqt_pkg::NumTerms];
  logic signed [FW-1:0] f5_q [piqt_pkg::NumTerms];

  always_comb begin
    logic signed [SumW-1:0] xsum;
    xsum = '0;
    for (int j = 0; j < piqt_pkg::NumTerms; j++) begin
      xsum    = SumW'(xa4_q[j]) + SumW'(xb4_q[j]);
      f5_d[j] = $signed({hh4_q[j], ll4_q[j]}) + (FW'(xsum) <<< LW);
    end
  end

  // stage 6: den, unum, vnum per triangle
  logic signed [NW-1:0] den6_d [piqt_pkg::NumTris];
  logic signed [NW-1:0] un6_d  [piqt_pkg::NumTris];
  logic signed [NW-1:0] vn6_d  [piqt_pkg::NumTris];
  logic signed [NW-1:0] den6_q [piqt_pkg::NumTris];
  logic signed [NW-1:0] un6_q  [piqt_pkg::NumTris];
  logic signed [NW-1:0] vn6_q  [piqt_pkg::NumTris];

  always_comb begin
    for (int t = 0; t < piqt_pkg::NumTris; t++) begin
      den6_d[t] = NW'(f5_q[t*piqt_pkg::TermsPerTri + piqt_pkg::TERM_DEN_P])
                - NW'(f5_q[t*piqt_pkg::TermsPerTri + piqt_pkg::TERM_DEN_N]);
      un6_d[t]  = NW'(f5_q[t*piqt_pkg::TermsPerTri + piqt_pkg::TERM_UN_P])
                - NW'(f5_q[t*piqt_pkg::TermsPerTri + piqt_pkg::TERM_UN_N]);
      vn6_d[t]  = NW'(f5_q[t*piqt_pkg::TermsPerTri + piqt_pkg::TERM_VN_P])
                - NW'(f5_q[t*piqt_pkg::TermsPerTri + piqt_pkg::TERM_VN_N]);
    end
  end

  // stage 7: sign checks folded by the sign of den, numerator sum
  logic signed [SW-1:0] sum7_d [piqt_pkg::NumTris];
  logic                 ok7_d  [piqt_pkg::NumTris];
  logic signed [SW-1:0] sum7_q [piqt_pkg::NumTris];
  logic signed [NW-1:0] den7_q [piqt_pkg::NumTris];
  logic                 ok7_q  [piqt_pkg::NumTris];

  always_comb begin
    logic un_neg;
    logic vn_neg;
    logic un_zero;
    logic vn_zero;
    un_neg  = 1'b0;
    vn_neg  = 1'b0;
    un_zero = 1'b0;
    vn_zero = 1'b0;
    for (int t = 0; t < piqt_pkg::NumTris; t++) begin
      sum7_d[t] = SW'(un6_q[t]) + SW'(vn6_q[t]);
      un_neg    = un6_q[t][NW-1];
      vn_neg    = vn6_q[t][NW-1];
      un_zero   = (un6_q[t] == '0);
      vn_zero   = (vn6_q[t] == '0);
      if (den6_q[t] == '0) begin
        ok7_d[t] = 1'b0;  // degenerate triangle counts as outside
      end else if (den6_q[t][NW-1]) begin
        ok7_d[t] = (un_neg | un_zero) & (vn_neg | vn_zero);
      end else begin
        ok7_d[t] = ~un_neg & ~vn_neg;
      end
    end
  end

  // stage 8: sum against den, negative den flips the compare
  logic hit8 [piqt_pkg::NumTris];
  logic danger_q;

  always_comb begin
    for (int t = 0; t < piqt_pkg::NumTris; t++) begin
      if (den7_q[t][NW-1]) begin
        hit8[t] = ok7_q[t] & (sum7_q[t] >= SW'(den7_q[t]));
      end else begin
        hit8[t] = ok7_q[t] & (sum7_q[t] <= SW'(den7_q[t]));
      end
    end
  end

  // stage payload registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_q   <= e1_d;
      p2_q   <= p2_d;
      d3_q   <= d3_d;
      hh4_q  <= hh4_d;
      ll4_q  <= ll4_d;
      xa4_q  <= xa4_d;
      xb4_q  <= xb4_d;
      f5_q   <= f5_d;
      den6_q <= den6_d;
      un6_q  <= un6_d;
      vn6_q  <= vn6_d;
      sum7_q <= sum7_d;
      den7_q <= den6_q;
      ok7_q  <= ok7_d;
      danger_q <= hit8[0] | hit8[1];
    end
  end

  assign in_danger_o  = danger_q;
  assign reply_port_o = port_q[NS-1];

  // ---------------------------------------------------------------------------
  // checks

  // an advancing pipeline moves every valid bit one stage on
  a_vld_shift : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> (vld_q[NS-1:1] == $past(vld_q[NS-2:0])))
    else $error("stage valid bits did not advance");

  // a stalled pipeline keeps every item in place
  a_vld_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("stage valid bits changed during a stall");

  // an empty output stage never blocks the input
  a_ready_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[NS-1] |-> in_ready_o)
    else $error("input blocked with an empty output stage");

  // a degenerate triangle never passes the sign checks
  a_degenerate : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NS-2] |-> !((ok7_q[0] && (den7_q[0] == '0)) || (ok7_q[1] && (den7_q[1] == '0))))
    else $error("degenerate triangle reported as a hit");

endmodule

`default_nettype wire

// File: bench/point_in_quadrilateral_test_top_tb.sv
// Testbench for point_in_quadrilateral_test_top: drives position reports under random
// backpressure and checks each answer against an exact integer danger-zone predictor.
// Depends on piqt_pkg and the point_in_quadrilateral_test_top RTL.
`timescale 1ns / 1ps

localparam int CoordW   = 20;
localparam int PortW    = 4;
localparam int CoordMin = -524288;
localparam int CoordMax = 524287;

typedef struct packed {
  longint x;
  longint y;
  longint z;
} vec3_t;

typedef struct packed {
  logic             danger;
  logic [PortW-1:0] port;
} answer_t;

class danger_board;
  logic [63:0] corner [4];
  answer_t     awaiting [$];
  int          errors;

  function new();
    foreach (corner[i]) corner[i] = '0;
    errors = 0;
  endfunction

  function void set_corner(logic [1:0] idx, logic [63:0] value);
    corner[idx] = value;
  endfunction

  function int pending();
    return awaiting.size();
  endfunction

  // only the low three coordinate fields count, upper bits are ignored
  function vec3_t corner_vec(logic [63:0] raw);
    vec3_t v;
    v.x = $signed(raw[CoordW-1:0]);
    v.y = $signed(raw[2*CoordW-1:CoordW]);
    v.z = $signed(raw[3*CoordW-1:2*CoordW]);
    return v;
  endfunction

  function vec3_t vdiff(vec3_t a, vec3_t b);
    vec3_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  function longint dot3(vec3_t a, vec3_t b);
    longint s;
    s = a.x * b.x + a.y * b.y + a.z * b.z;
    return s;
  endfunction

  // barycentric test with the division folded into sign-corrected compares
  function bit tri_hit(vec3_t p, vec3_t a, vec3_t b, vec3_t c);
    vec3_t               e0, e1, e2;
    longint              d00, d01, d11, d20, d21;
    logic signed [127:0] w00, w01, w11, w20, w21, den, un, vn;
    e0  = vdiff(b, a);
    e1  = vdiff(c, a);
    e2  = vdiff(p, a);
    d00 = dot3(e0, e0);
    d01 = dot3(e0, e1);
    d11 = dot3(e1, e1);
    d20 = dot3(e2, e0);
    d21 = dot3(e2, e1);
    w00 = d00;
    w01 = d01;
    w11 = d11;
    w20 = d20;
    w21 = d21;
    den = w00 * w11 - w01 * w01;
    un  = w11 * w20 - w01 * w21;
    vn  = w00 * w21 - w01 * w20;
    // degenerate triangle never contains the point
    if (den == 0) return 1'b0;
    if (den < 0) begin
      den = -den;
      un  = -un;
      vn  = -vn;
    end
    return (un >= 0) && (vn >= 0) && (un + vn <= den);
  endfunction

  function void note_report(logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                            logic [CoordW-1:0] z, logic [PortW-1:0] port);
    vec3_t   p, a, b, c, d;
    answer_t ans;
    p.x = $signed(x);
    p.y = $signed(y);
    p.z = $signed(z);
    a = corner_vec(corner[0]);
    b = corner_vec(corner[1]);
    c = corner_vec(corner[2]);
    d = corner_vec(corner[3]);
    ans.danger = tri_hit(p, a, b, c) || tri_hit(p, a, c, d);
    ans.port   = port;
    awaiting = {awaiting, ans};
  endfunction

  function void check_answer(logic danger, logic [PortW-1:0] port);
    answer_t want;
    if (awaiting.size() == 0) begin
      $display("%0t answer with no report pending: in_danger %0b reply_port %0d",
               $time, danger, port);
      errors++;
      return;
    end
    want = awaiting.pop_front();
    if (danger !== want.danger) begin
      $display("%0t in_danger mismatch: expected %0b actual %0b",
               $time, want.danger, danger);
      errors++;
    end
    if (port !== want.port) begin
      $display("%0t reply_port mismatch: expected %0d actual %0d",
               $time, want.port, port);
      errors++;
    end
  endfunction
endclass

module point_in_quadrilateral_test_top_tb;

  localparam int HoldCycles  = 300;
  localparam int StallLimit  = 4000;
  localparam int PhaseItems  = 130;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         psel          = 1'b0;
  logic                         penable       = 1'b0;
  logic                         pwrite        = 1'b0;
  logic [piqt_pkg::AddrW-1:0]   paddr         = '0;
  logic [piqt_pkg::DataW-1:0]   pwdata        = '0;
  logic [piqt_pkg::DataW-1:0]   prdata;
  logic                         pready;
  logic                         in_valid_i    = 1'b0;
  logic                         in_ready_o;
  logic signed [CoordW-1:0]     pos_x_i       = '0;
  logic signed [CoordW-1:0]     pos_y_i       = '0;
  logic signed [CoordW-1:0]     pos_z_i       = '0;
  logic [PortW-1:0]             client_port_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i   = 1'b0;
  logic                         in_danger_o;
  logic [PortW-1:0]             reply_port_o;

  danger_board board;
  int          answers_seen = 0;
  int          stall_cycles = 0;
  int          burst_left   = 1;
  int          quad [3][4];  // [axis][corner]

  point_in_quadrilateral_test_top #(
    .MAX_CLIENTS(16),
    .COORD_BITS (CoordW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .client_port_i(client_port_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .in_danger_o  (in_danger_o),
    .reply_port_o (reply_port_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_answer(in_danger_o, reply_port_o);
      answers_seen <= answers_seen + 1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (stall_cycles >= StallLimit);
    $display("%0t no item moved for %0d cycles", $time, StallLimit);
    $display("tb: failure");
    $finish;
  end

  // receiver: segments of free flow, light and heavy stalling, plus one long hold
  initial begin : receiver
    int  seg_left;
    int  seg_kind;
    bit  hold_done;
    seg_left  = 0;
    seg_kind  = 0;
    hold_done = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (!hold_done && answers_seen >= 200) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        if (seg_left == 0) begin
          seg_kind = $urandom_range(0, 2);
          seg_left = $urandom_range(1, 40);
        end
        seg_left--;
        case (seg_kind)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= ($urandom_range(0, 1) == 1);
          default: out_ready_i <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [piqt_pkg::DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    board.set_corner(idx, value);
    @(posedge clk_i);
  endtask

  // junk in the unused top bits must not matter
  function automatic logic [piqt_pkg::DataW-1:0] pack_corner(int k);
    logic [3:0] junk;
    junk = $urandom_range(0, 15);
    return {junk, CoordW'(quad[2][k]), CoordW'(quad[1][k]), CoordW'(quad[0][k])};
  endfunction

  task automatic load_quad();
    write_reg(piqt_pkg::CORNER_A, pack_corner(0));
    write_reg(piqt_pkg::CORNER_B, pack_corner(1));
    write_reg(piqt_pkg::CORNER_C, pack_corner(2));
    write_reg(piqt_pkg::CORNER_D, pack_corner(3));
  endtask

  // leaves valid high after the accept, unless the burst ends, so the next item can follow back to back
  task automatic send_report(input int x, input int y, input int z, input int port);
    in_valid_i    <= 1'b1;
    pos_x_i       <= x[CoordW-1:0];
    pos_y_i       <= y[CoordW-1:0];
    pos_z_i       <= z[CoordW-1:0];
    client_port_i <= port[PortW-1:0];
    do @(posedge clk_i); while (!in_ready_o);
    board.note_report(pos_x_i, pos_y_i, pos_z_i, client_port_i);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic drain_answers();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (piqt_pkg::NumStages + 4) @(posedge clk_i);
  endtask

  function automatic int corner_coord(int kind);
    case (kind)
      0:       return int'($urandom_range(0, 600)) - 300;
      1:       return int'($urandom_range(0, 60000)) - 30000;
      2:       return int'($urandom_range(0, 1048575)) + CoordMin;
      3:       return int'($urandom_range(0, 10000)) - 5000;
      default: return ($urandom_range(0, 1) == 1) ? CoordMax : CoordMin;
    endcase
  endfunction

  // mostly points around the quadrilateral, some near a corner, some anywhere
  function automatic int pick_axis(int ax, int mode, int k);
    int lo;
    int hi;
    int margin;
    lo = quad[ax][0];
    hi = lo;
    for (int i = 1; i < 4; i++) begin
      if (quad[ax][i] < lo) lo = quad[ax][i];
      if (quad[ax][i] > hi) hi = quad[ax][i];
    end
    if (mode < 6) begin
      margin = (hi - lo) / 8 + 2;
      lo -= margin;
      hi += margin;
    end else if (mode < 8) begin
      lo = quad[ax][k] - 4;
      hi = quad[ax][k] + 4;
    end else begin
      lo = CoordMin;
      hi = CoordMax;
    end
    if (lo < CoordMin) lo = CoordMin;
    if (hi > CoordMax) hi = CoordMax;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  initial begin : stimulus
    int mode;
    int k;
    int flat_z;
    board = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners still at reset: every triangle is degenerate
    send_report(0, 0, 0, 0);
    send_report(CoordMax, CoordMin, CoordMax, 15);
    send_report(CoordMin, CoordMax, CoordMin, 7);
    drain_answers();

    // 100 by 100 square in the z=0 plane
    quad = '{'{0, 100, 100, 0}, '{0, 0, 100, 100}, '{0, 0, 0, 0}};
    load_quad();
    send_report(50, 50, 0, 1);
    send_report(0, 0, 0, 2);
    send_report(100, 50, 0, 3);
    send_report(90, 10, 0, 4);
    send_report(10, 90, 0, 5);
    send_report(101, 50, 0, 6);
    send_report(-1, 0, 0, 8);
    send_report(50, 50, 5000, 9);
    send_report(50, 101, -3, 10);
    send_report(CoordMax, CoordMax, CoordMin, 15);
    drain_answers();

    // corners at the coordinate extremes stress the widest products
    quad = '{'{CoordMin, CoordMax, CoordMax, CoordMin},
             '{CoordMin, CoordMin, CoordMax, CoordMax},
             '{CoordMin, CoordMin, CoordMax, CoordMax}};
    load_quad();
    send_report(CoordMax, CoordMax, CoordMax, 11);
    send_report(CoordMin, CoordMin, CoordMin, 12);
    send_report(0, 0, 0, 13);
    send_report(CoordMax, CoordMin, 0, 14);
    send_report(CoordMin, CoordMax, CoordMax, 0);
    drain_answers();

    // D on the diagonal AC: second triangle collapses to a line
    quad = '{'{0, 200, 200, 100}, '{0, 0, 200, 100}, '{0, 0, 0, 0}};
    load_quad();
    send_report(150, 50, 0, 3);
    send_report(50, 100, 0, 5);
    send_report(100, 100, 0, 9);
    drain_answers();

    for (int kind = 0; kind < 5; kind++) begin
      flat_z = corner_coord(2);
      for (int c = 0; c < 4; c++) begin
        quad[0][c] = corner_coord(kind);
        quad[1][c] = corner_coord(kind);
        quad[2][c] = (kind == 3) ? flat_z : corner_coord(kind);
      end
      load_quad();
      for (int i = 0; i < PhaseItems; i++) begin
        if (i == PhaseItems / 2) drain_answers();
        mode = $urandom_range(0, 9);
        k    = $urandom_range(0, 3);
        send_report(pick_axis(0, mode, k), pick_axis(1, mode, k),
                    pick_axis(2, mode, k), $urandom_range(0, 15));
      end
      drain_answers();
    end

    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
